>>> sv/group_exclusive_task_dispatcher_defines.svh
// Assertion macros shared by the dispatcher RTL.
`ifndef GROUP_EXCLUSIVE_TASK_DISPATCHER_DEFINES_SVH
`define GROUP_EXCLUSIVE_TASK_DISPATCHER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GETD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GETD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/getd_pkg.sv
package getd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int GROUP_COUNT = 16;
    localparam int TAG_BITS    = 16;

    localparam int PORT_TAG_W  = 16;
    localparam int STORE_TAG_W = (TAG_BITS < PORT_TAG_W) ? TAG_BITS : PORT_TAG_W;
    localparam int GRP_W       = $clog2(GROUP_COUNT);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ACT_W       = 8;
    localparam logic [ACT_W-1:0] ACTIVE_MAX = 8'd255;

    typedef logic [1:0] func_t;
    localparam func_t FN_ENQ  = 2'd0;
    localparam func_t FN_DISP = 2'd1;
    localparam func_t FN_DONE = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_FULL    = 2'd1;
    localparam status_t ST_NONE    = 2'd2;
    localparam status_t ST_NOTBUSY = 2'd3;

    typedef struct packed {
        logic [STORE_TAG_W-1:0] tag;
        logic [GRP_W-1:0]       grp;
        logic                   excl;
    } entry_t;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic [IDX_W-1:0] pop_pos;
    } q_ctrl_t;

    function automatic logic [GRP_W-1:0] group_index(input logic [3:0] g);
        logic [8:0] r;
        r = {5'd0, g};
        for (int k = 0; k < 8; k++) begin
            if (r >= 9'(GROUP_COUNT)) begin
                r = r - 9'(GROUP_COUNT);
            end
        end
        return r[GRP_W-1:0];
    endfunction

endpackage

>>> sv/getd_queue.sv
module getd_queue (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  getd_pkg::q_ctrl_t            ctrl,
    input  getd_pkg::entry_t             push_entry,
    input  logic [getd_pkg::IDX_W-1:0]   rd_idx,
    output getd_pkg::entry_t             rd_entry,
    output logic [getd_pkg::CNT_W-1:0]   count
);
    import getd_pkg::*;

    entry_t           mem_reg  [QUEUE_DEPTH];
    entry_t           mem_next [QUEUE_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // A pop closes the gap by moving every later entry down by one.
    always_comb begin
        mem_next   = mem_reg;
        count_next = count_reg;
        if (ctrl.pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                if (IDX_W'(i) >= ctrl.pop_pos) begin
                    mem_next[i] = mem_reg[i + 1];
                end
            end
            count_next = count_reg - CNT_W'(1);
        end else if (ctrl.push) begin
            mem_next[count_reg[IDX_W-1:0]] = push_entry;
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        mem_reg <= mem_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign rd_entry = mem_reg[rd_idx];
    assign count    = count_reg;

endmodule

>>> sv/group_exclusive_task_dispatcher.sv
// Task queue with per-group mutual exclusion.
// The input channel (s_valid/s_ready) carries one command per transaction:
// enqueue a task, request the next task for a worker, or report a task done.
// Every input transaction produces exactly one result transaction on the
// m_valid/m_ready channel with grant, task fields, status and an idle flag.
// Enqueue, done and unknown commands skip the scan, raise m_valid once they
// commit, and then let the block return to idle for the next command.
// A dispatch walks the queue oldest first, one entry per cycle through a
// single eligibility check, and stops at the first eligible entry or at
// the last one, inspecting at most the queue depth of 16 entries and none
// when the queue is empty; its result then commits like the others.
// The block accepts one command at a time; s_ready is high only while no
// command is in progress.
// When the receiver stalls, the finished result waits in the output register
// and the command commits only once that register is free, so s_ready stays
// low until then.
// Reset empties the queue, clears all group busy marks and the active count,
// and drops any pending result.
`include "group_exclusive_task_dispatcher_defines.svh"

module group_exclusive_task_dispatcher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_task_tag,
    input  logic [3:0]  s_group_num,
    input  logic        s_is_exclusive,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_granted,
    output logic [15:0] m_out_tag,
    output logic [3:0]  m_out_group,
    output logic        m_out_exclusive,
    output logic [1:0]  m_status,
    output logic        m_idle
);
    import getd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t                 state_reg,     state_next;
    func_t                  func_reg,      func_next;
    logic [STORE_TAG_W-1:0] tag_reg,       tag_next;
    logic [GRP_W-1:0]       grp_reg,       grp_next;
    logic                   excl_reg,      excl_next;
    logic [IDX_W-1:0]       idx_reg,       idx_next;
    logic                   hit_reg,       hit_next;
    entry_t                 hit_entry_reg, hit_entry_next;
    logic [GROUP_COUNT-1:0] busy_reg,      busy_next;
    logic [ACT_W-1:0]       active_reg,    active_next;
    logic                   m_valid_reg,   m_valid_next;
    logic                   granted_reg,   granted_next;
    logic [15:0]            out_tag_reg,   out_tag_next;
    logic [3:0]             out_group_reg, out_group_next;
    logic                   out_excl_reg,  out_excl_next;
    status_t                status_reg,    status_next;
    logic                   idle_reg,      idle_next;

    q_ctrl_t          ctrl;
    entry_t           push_entry;
    entry_t           cand;
    logic [CNT_W-1:0] q_count;
    logic [CNT_W-1:0] q_after;
    logic             cand_ok;
    logic             last;
    logic             out_free;
    logic             commit;
    logic             full;

    getd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .push_entry (push_entry),
        .rd_idx     (idx_reg),
        .rd_entry   (cand),
        .count      (q_count)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign cand_ok  = !cand.excl || !busy_reg[cand.grp];
    assign last     = (CNT_W'(idx_reg) + CNT_W'(1)) == q_count;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == S_FIN) && out_free;
    assign full     = (q_count == CNT_W'(QUEUE_DEPTH));

    assign push_entry.tag  = tag_reg;
    assign push_entry.grp  = excl_reg ? grp_reg : '0;
    assign push_entry.excl = excl_reg;

    assign ctrl.push    = commit && (func_reg == FN_ENQ) && !full;
    assign ctrl.pop     = commit && (func_reg == FN_DISP) && hit_reg;
    assign ctrl.pop_pos = idx_reg;

    assign q_after = ctrl.push ? (q_count + CNT_W'(1)) :
                     ctrl.pop  ? (q_count - CNT_W'(1)) : q_count;

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        tag_next       = tag_reg;
        grp_next       = grp_reg;
        excl_next      = excl_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        hit_entry_next = hit_entry_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next = s_func;
                    tag_next  = s_task_tag[STORE_TAG_W-1:0];
                    grp_next  = group_index(s_group_num);
                    excl_next = s_is_exclusive;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    if ((s_func == FN_DISP) && (q_count != '0)) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                if (cand_ok) begin
                    hit_next       = 1'b1;
                    hit_entry_next = cand;
                    state_next     = S_FIN;
                end else if (last) begin
                    state_next = S_FIN;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy_next      = busy_reg;
        active_next    = active_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        granted_next   = granted_reg;
        out_tag_next   = out_tag_reg;
        out_group_next = out_group_reg;
        out_excl_next  = out_excl_reg;
        status_next    = status_reg;
        idle_next      = idle_reg;
        if (commit) begin
            granted_next   = 1'b0;
            out_tag_next   = '0;
            out_group_next = '0;
            out_excl_next  = 1'b0;
            status_next    = ST_OK;
            case (func_reg)
                FN_ENQ: begin
                    if (full) begin
                        status_next = ST_FULL;
                    end
                end
                FN_DISP: begin
                    if (hit_reg) begin
                        granted_next   = 1'b1;
                        out_tag_next   = 16'(hit_entry_reg.tag);
                        out_group_next = 4'(hit_entry_reg.grp);
                        out_excl_next  = hit_entry_reg.excl;
                        if (hit_entry_reg.excl) begin
                            busy_next[hit_entry_reg.grp] = 1'b1;
                        end
                        if (active_reg != ACTIVE_MAX) begin
                            active_next = active_reg + ACT_W'(1);
                        end
                    end else begin
                        status_next = ST_NONE;
                    end
                end
                FN_DONE: begin
                    if (excl_reg) begin
                        if (!busy_reg[grp_reg]) begin
                            status_next = ST_NOTBUSY;
                        end
                        busy_next[grp_reg] = 1'b0;
                    end
                    if (active_reg != '0) begin
                        active_next = active_reg - ACT_W'(1);
                    end
                end
                default: begin
                    status_next = ST_OK;
                end
            endcase
            idle_next    = (q_after == '0) && (active_next == '0);
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            busy_reg    <= '0;
            active_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        tag_reg       <= tag_next;
        grp_reg       <= grp_next;
        excl_reg      <= excl_next;
        idx_reg       <= idx_next;
        hit_reg       <= hit_next;
        hit_entry_reg <= hit_entry_next;
        granted_reg   <= granted_next;
        out_tag_reg   <= out_tag_next;
        out_group_reg <= out_group_next;
        out_excl_reg  <= out_excl_next;
        status_reg    <= status_next;
        idle_reg      <= idle_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_granted       = granted_reg;
    assign m_out_tag       = out_tag_reg;
    assign m_out_group     = out_group_reg;
    assign m_out_exclusive = out_excl_reg;
    assign m_status        = status_reg;
    assign m_idle          = idle_reg;

    `GETD_ASSERT_IMPL(a_count_bound, 1'b1, q_count <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
    `GETD_ASSERT_IMPL(a_scan_range, state_reg == S_SCAN, CNT_W'(idx_reg) < q_count, "scan past queue end")
    `GETD_ASSERT_IMPL(a_grant_status, m_valid && m_granted, (m_status == ST_OK) && !m_idle, "grant with bad status or idle")
    `GETD_ASSERT_NEXT(a_excl_busy, ctrl.pop && hit_entry_reg.excl, busy_reg[$past(hit_entry_reg.grp)], "exclusive grant left group free")

endmodule
